// ===== hw/rtl/ibfsg_pkg.sv =====
// ibfsg_pkg: symbol codes, item and digit types, bcd helper for the time code frame generator
// no dependencies; used by the interfaces, the symbol selector, the top level and the checker
`default_nettype none

package ibfsg_pkg;

    localparam logic       OP_LOAD = 1'b0;
    localparam logic       OP_EMIT = 1'b1;

    localparam logic [2:0] SYM_ZERO = 3'd0;
    localparam logic [2:0] SYM_ONE  = 3'd1;
    localparam logic [2:0] SYM_POS  = 3'd2;
    localparam logic [2:0] SYM_REF  = 3'd3;
    localparam logic [2:0] SYM_IDX  = 3'd4;

    localparam logic [6:0] LAST_POS = 7'd99;

    typedef struct packed {
        logic        operation;
        logic [5:0]  time_seconds;
        logic [5:0]  time_minutes;
        logic [4:0]  time_hours;
        logic [8:0]  day_of_year;
        logic [6:0]  year_two_digit;
        logic [16:0] seconds_of_day;
    } t_in_item;

    typedef struct packed {
        logic [2:0] symbol;
        logic       frame_end;
    } t_out_item;

    // bcd digits as sent, upper digit bits beyond the slot widths already dropped
    typedef struct packed {
        logic [3:0]  sec_units;
        logic [2:0]  sec_tens;
        logic [3:0]  min_units;
        logic [2:0]  min_tens;
        logic [3:0]  hr_units;
        logic [1:0]  hr_tens;
        logic [3:0]  day_units;
        logic [3:0]  day_tens;
        logic [1:0]  day_hund;
        logic [3:0]  yr_units;
        logic [3:0]  yr_tens;
        logic [16:0] day_seconds;
    } t_digits;

    // quotient by ten via reciprocal multiply, exact for all 9-bit values
    function automatic logic [5:0] div10(input logic [8:0] v);
        logic [16:0] prod;
        prod = 17'(v) * 17'd205;
        return prod[16:11];
    endfunction

    function automatic logic [3:0] rem10(input logic [8:0] v, input logic [5:0] q);
        logic [8:0] diff;
        diff = v - 9'(q) * 9'd10;
        return diff[3:0];
    endfunction

    function automatic logic [2:0] bit_sym(input logic b);
        return b ? SYM_ONE : SYM_ZERO;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ibfsg_if.sv =====
// ibfsg_in_if / ibfsg_out_if: valid-ready channels for input and result transactions
// depends on ibfsg_pkg for the payload types
`default_nettype none

interface ibfsg_in_if import ibfsg_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ibfsg_out_if import ibfsg_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ibfsg_symbol_sel.sv =====
// ibfsg_symbol_sel: maps frame position and held bcd digits to the symbol code
// depends on ibfsg_pkg
`default_nettype none

module ibfsg_symbol_sel import ibfsg_pkg::*; (
    input  wire t_digits    i_digits,
    input  wire logic [6:0] i_position,
    output logic [2:0]      o_symbol,
    output logic            o_frame_end
);

    always_comb begin
        o_frame_end = (i_position == LAST_POS);
        case (i_position) inside
            7'd0:
                o_symbol = SYM_REF;
            7'd9, 7'd19, 7'd29, 7'd39, 7'd49, 7'd59, 7'd69, 7'd79, 7'd89, 7'd99:
                o_symbol = SYM_POS;
            [7'd1:7'd4]:
                o_symbol = bit_sym(i_digits.sec_units[2'(i_position - 7'd1)]);
            [7'd6:7'd8]:
                o_symbol = bit_sym(i_digits.sec_tens[2'(i_position - 7'd6)]);
            [7'd10:7'd13]:
                o_symbol = bit_sym(i_digits.min_units[2'(i_position - 7'd10)]);
            [7'd15:7'd17]:
                o_symbol = bit_sym(i_digits.min_tens[2'(i_position - 7'd15)]);
            [7'd20:7'd23]:
                o_symbol = bit_sym(i_digits.hr_units[2'(i_position - 7'd20)]);
            [7'd25:7'd26]:
                o_symbol = bit_sym(i_digits.hr_tens[1'(i_position - 7'd25)]);
            [7'd30:7'd33]:
                o_symbol = bit_sym(i_digits.day_units[2'(i_position - 7'd30)]);
            [7'd35:7'd38]:
                o_symbol = bit_sym(i_digits.day_tens[2'(i_position - 7'd35)]);
            [7'd40:7'd41]:
                o_symbol = bit_sym(i_digits.day_hund[1'(i_position - 7'd40)]);
            [7'd50:7'd53]:
                o_symbol = bit_sym(i_digits.yr_units[2'(i_position - 7'd50)]);
            [7'd55:7'd58]:
                o_symbol = bit_sym(i_digits.yr_tens[2'(i_position - 7'd55)]);
            [7'd80:7'd88]:
                o_symbol = bit_sym(i_digits.day_seconds[5'(i_position - 7'd80)]);
            // second half of seconds of day skips the position marker at 89
            [7'd90:7'd97]:
                o_symbol = bit_sym(i_digits.day_seconds[5'(i_position - 7'd81)]);
            7'd5, 7'd14, 7'd18, 7'd24, 7'd27, 7'd28, 7'd34, [7'd42:7'd48], 7'd54, 7'd98:
                o_symbol = SYM_IDX;
            default:
                o_symbol = SYM_ZERO;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/irig_b_frame_symbol_generator.sv =====
// time code frame generator: the result of an accepted emit transaction is registered;
// throughput one transaction per cycle, loads and emits alike, while input ready is high.
// a one-entry skid stage behind the output register keeps input ready high while one
// result waits; input stalls only when both are full.
// synchronous active-low reset clears held time, frame position and both output stages.
// depends on ibfsg_pkg, ibfsg_if and ibfsg_symbol_sel
`default_nettype none

module irig_b_frame_symbol_generator import ibfsg_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ibfsg_in_if.sink     i_in,
    ibfsg_out_if.source  o_out
);

    t_digits    r_digits, n_digits;
    logic [6:0] r_pos, n_pos;

    logic       r_out_valid, n_out_valid;
    t_out_item  r_out_data, n_out_data;
    logic       r_skid_valid, n_skid_valid;
    t_out_item  r_skid_data, n_skid_data;

    t_out_item  w_new;
    logic       w_accept;
    logic       w_emit;

    // bcd split of the load fields
    logic [5:0] w_sec_q, w_min_q, w_hr_q, w_yr_q, w_day_q, w_day_q2;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_emit   = w_accept && (i_in.payload.operation == OP_EMIT);

    ibfsg_symbol_sel u_sel (
        .i_digits    (r_digits),
        .i_position  (r_pos),
        .o_symbol    (w_new.symbol),
        .o_frame_end (w_new.frame_end)
    );

    always_comb begin
        w_sec_q  = div10({3'b000, i_in.payload.time_seconds});
        w_min_q  = div10({3'b000, i_in.payload.time_minutes});
        w_hr_q   = div10({4'b0000, i_in.payload.time_hours});
        w_yr_q   = div10({2'b00, i_in.payload.year_two_digit});
        w_day_q  = div10(i_in.payload.day_of_year);
        w_day_q2 = div10({3'b000, w_day_q});

        n_digits = r_digits;
        n_pos    = r_pos;
        if (w_accept) begin
            if (i_in.payload.operation == OP_LOAD) begin
                n_digits.sec_units   = rem10({3'b000, i_in.payload.time_seconds}, w_sec_q);
                n_digits.sec_tens    = w_sec_q[2:0];
                n_digits.min_units   = rem10({3'b000, i_in.payload.time_minutes}, w_min_q);
                n_digits.min_tens    = w_min_q[2:0];
                n_digits.hr_units    = rem10({4'b0000, i_in.payload.time_hours}, w_hr_q);
                n_digits.hr_tens     = w_hr_q[1:0];
                n_digits.day_units   = rem10(i_in.payload.day_of_year, w_day_q);
                n_digits.day_tens    = rem10({3'b000, w_day_q}, w_day_q2);
                n_digits.day_hund    = w_day_q2[1:0];
                n_digits.yr_units    = rem10({2'b00, i_in.payload.year_two_digit}, w_yr_q);
                // year tens is at most twelve, one subtract folds it
                n_digits.yr_tens     = (w_yr_q >= 6'd10) ? 4'(w_yr_q - 6'd10) : w_yr_q[3:0];
                n_digits.day_seconds = i_in.payload.seconds_of_day;
                n_pos                = 7'd0;
            end else begin
                n_pos = (r_pos >= LAST_POS) ? 7'd0 : r_pos + 7'd1;
            end
        end
    end

    // output register with skid entry
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            if (o_out.ready) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (!r_out_valid || o_out.ready) begin
            n_out_valid = w_emit;
            n_out_data  = w_new;
        end else if (w_emit) begin
            n_skid_valid = 1'b1;
            n_skid_data  = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits     <= '0;
            r_pos        <= 7'd0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_digits     <= n_digits;
            r_pos        <= n_pos;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign i_in.ready    = !r_skid_valid;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_data;

endmodule

`default_nettype wire

// ===== hw/rtl/ibfsg_checker.sv =====
// ibfsg_checker: port-level assertions for the time code frame generator, bound to the top level
// depends on ibfsg_pkg
`default_nettype none

module ibfsg_checker import ibfsg_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] i_symbol,
    input wire logic       i_frame_end
);

    // a stalled result transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // input stalls only when the output register is full as well
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with empty output register");

    a_symbol_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_symbol == SYM_ZERO || i_symbol == SYM_ONE || i_symbol == SYM_POS
                         || i_symbol == SYM_REF || i_symbol == SYM_IDX))
        else $error("symbol code out of range");

    // last symbol of the frame is always a position marker
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_end |-> i_symbol == SYM_POS)
        else $error("frame end without position marker");

    // skid full only after an offered transaction met a stalled output
    a_skid_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_in_valid && i_out_valid && !i_out_ready))
        else $error("input stall without stalled output");

endmodule

bind irig_b_frame_symbol_generator ibfsg_checker u_ibfsg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_symbol    (o_out.payload.symbol),
    .i_frame_end (o_out.payload.frame_end)
);

`default_nettype wire

// ===== verif/tb.sv =====
// tb: self-checking bench for irig_b_frame_symbol_generator, directed then random transactions
// depends on ibfsg_pkg, ibfsg_if and the generator rtl; the expected frame is rebuilt in the class
`timescale 1ns / 100ps

import ibfsg_pkg::*;

class frame_scoreboard;
    t_out_item   pending_symbols[$];
    logic [5:0]  held_sec = '0;
    logic [5:0]  held_min = '0;
    logic [4:0]  held_hr = '0;
    logic [8:0]  held_doy = '0;
    logic [6:0]  held_yr = '0;
    logic [16:0] held_sod = '0;
    logic [6:0]  frame_pos = '0;
    int unsigned mismatches = 0;

    function logic [2:0] digit_bit(int unsigned v, int unsigned b);
        logic [31:0] bits;
        bits = v;
        return bits[b] ? SYM_ONE : SYM_ZERO;
    endfunction

    // units nibble first, index marker, then the tens bits that fit; the rest is index filler
    function logic [2:0] bcd_slot(int unsigned v, int unsigned off, int unsigned tens_width);
        int unsigned units;
        int unsigned tens;
        units = v % 10;
        tens  = (v / 10) % 10;
        if (off < 4)
            return digit_bit(units, off);
        if (off == 4)
            return SYM_IDX;
        if (off - 5 < tens_width)
            return digit_bit(tens, off - 5);
        return SYM_IDX;
    endfunction

    function logic [2:0] symbol_for_position(int unsigned pos);
        int unsigned grp;
        int unsigned off;
        grp = pos / 10;
        off = pos % 10;
        if (pos == 0)
            return SYM_REF;
        if (off == 9)
            return SYM_POS;
        case (grp)
            0: return bcd_slot(held_sec, off - 1, 3);
            1: return bcd_slot(held_min, off, 3);
            2: return bcd_slot(held_hr, off, 2);
            3: return bcd_slot(held_doy, off, 4);
            4: return (off < 2) ? digit_bit(held_doy / 100, off) : SYM_IDX;
            5: return bcd_slot(held_yr, off, 4);
            8: return digit_bit(held_sod, off);
            9: return (off < 8) ? digit_bit(held_sod, off + 9) : SYM_IDX;
            default: return SYM_ZERO;
        endcase
    endfunction

    function void note_input(t_in_item it);
        t_out_item   sym;
        int unsigned pos;
        if (it.operation == OP_LOAD) begin
            held_sec  = it.time_seconds;
            held_min  = it.time_minutes;
            held_hr   = it.time_hours;
            held_doy  = it.day_of_year;
            held_yr   = it.year_two_digit;
            held_sod  = it.seconds_of_day;
            frame_pos = '0;
        end else begin
            pos = (frame_pos >= 100) ? 0 : frame_pos;
            sym.symbol    = symbol_for_position(pos);
            sym.frame_end = (pos == LAST_POS);
            pending_symbols.insert(pending_symbols.size(), sym);
            frame_pos = (pos >= LAST_POS) ? 7'd0 : 7'(pos + 1);
        end
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        if (pending_symbols.size() == 0) begin
            $error("unexpected result: symbol %0d frame_end %0d", got.symbol, got.frame_end);
            mismatches++;
            return;
        end
        want = pending_symbols.pop_front();
        if (got.symbol !== want.symbol) begin
            $error("symbol mismatch: expected %0d, actual %0d", want.symbol, got.symbol);
            mismatches++;
        end
        if (got.frame_end !== want.frame_end) begin
            $error("frame_end mismatch: expected %0d, actual %0d", want.frame_end,
                   got.frame_end);
            mismatches++;
        end
    endfunction
endclass

module tb;
    localparam int RANDOM_ITEMS = 680;
    localparam int STUCK_LIMIT  = 2000;

    logic clk;
    logic rst_n;
    logic quiet;
    int   stuck_cycles;

    ibfsg_in_if  in_ch ();
    ibfsg_out_if out_ch ();

    frame_scoreboard frame_sb = new();

    irig_b_frame_symbol_generator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 8);
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready)
            frame_sb.check_result(out_ch.payload);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("irig_b_frame_symbol_generator test failed");
                $finish;
            end
        end
    end

    task automatic send_item(input t_in_item it);
        while (!quiet && $urandom_range(99) < 8) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        frame_sb.note_input(it);
    endtask

    task automatic send_load(input int unsigned sec, input int unsigned mins,
                             input int unsigned hrs, input int unsigned doy,
                             input int unsigned yr, input int unsigned sod);
        t_in_item it;
        it.operation      = OP_LOAD;
        it.time_seconds   = 6'(sec);
        it.time_minutes   = 6'(mins);
        it.time_hours     = 5'(hrs);
        it.day_of_year    = 9'(doy);
        it.year_two_digit = 7'(yr);
        it.seconds_of_day = 17'(sod);
        send_item(it);
    endtask

    // time fields are ignored on an emit, so they carry noise
    task automatic send_emits(input int unsigned count);
        t_in_item    it;
        logic [63:0] noise;
        repeat (count) begin
            noise        = {$urandom, $urandom};
            it           = noise[$bits(t_in_item)-1:0];
            it.operation = OP_EMIT;
            send_item(it);
        end
    endtask

    initial begin
        int unsigned n;

        rst_n         <= 1'b0;
        quiet         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // emit before any load sends the all-zero time frame
        send_emits(3);
        // every field at the top of its width, beyond the legal digit ranges
        send_load(63, 63, 31, 511, 127, 131071);
        send_emits(10);
        send_load(59, 59, 23, 399, 99, 0);
        send_emits(5);
        send_load(0, 0, 0, 0, 0, 86399);
        send_emits(2);

        n = 0;
        while (n < RANDOM_ITEMS) begin
            quiet <= (n >= 250 && n < 400);
            if ($urandom_range(999) < 8) begin
                if ($urandom_range(3) == 0)
                    send_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                else
                    send_load($urandom_range(59), $urandom_range(59), $urandom_range(23),
                              $urandom_range(399), $urandom_range(99),
                              $urandom_range(131071));
            end else begin
                send_emits(1);
            end
            n++;
        end
        in_ch.valid <= 1'b0;
        quiet       <= 1'b0;

        while (frame_sb.pending_symbols.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (frame_sb.mismatches == 0)
            $display("irig_b_frame_symbol_generator test passed");
        else
            $display("irig_b_frame_symbol_generator test failed");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/ibfsg_pkg.sv
hw/rtl/ibfsg_if.sv
hw/rtl/ibfsg_symbol_sel.sv
hw/rtl/irig_b_frame_symbol_generator.sv
hw/rtl/ibfsg_checker.sv
verif/tb.sv
